FILE: hw/rtl/btpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpf_pkg: shared definitions for the binary trie prefix filter
// Default sizes and operation codes used by the interfaces and the top level.
// ----------------------------------------------------------------------------
package btpf_pkg;

	localparam int BTPF_NODES        = 4096;
	localparam int BTPF_ADDRESS_BITS = 32;

	// operation carried by an input item
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

endpackage

FILE: hw/rtl/btpf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpf_req_if: request channel of the prefix filter
// Valid/ready channel carrying one insert or lookup item.
// ----------------------------------------------------------------------------
interface btpf_req_if
	import btpf_pkg::*;
#(
	parameter int ADDRESS_BITS = BTPF_ADDRESS_BITS
);
	localparam int LENW = $clog2(ADDRESS_BITS + 1);

	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [ADDRESS_BITS-1:0] prefix;
	logic [LENW-1:0]         length;

	modport source (output valid, output kind, output prefix, output length, input ready);
	modport sink   (input valid, input kind, input prefix, input length, output ready);
endinterface

FILE: hw/rtl/btpf_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpf_rsp_if: result channel of the prefix filter
// Valid/ready channel carrying one result item per request item.
// ----------------------------------------------------------------------------
interface btpf_rsp_if
	import btpf_pkg::*;
#(
	parameter int NODES = BTPF_NODES
);
	localparam int CNTW = $clog2(NODES + 1);

	logic            valid;
	logic            ready;
	logic            hit;
	logic [CNTW-1:0] node_count;
	logic            pool_full;

	modport source (output valid, output hit, output node_count, output pool_full, input ready);
	modport sink   (input valid, input hit, input node_count, input pool_full, output ready);
endinterface

FILE: hw/rtl/btpf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpf_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module btpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/binary_trie_prefix_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_prefix_filter: address prefix store and match
// Binary trie of address prefixes kept in a node memory, walked one level per
// cycle for inserts and lookups.
// ----------------------------------------------------------------------------
// Each request item is an insert (kind 0) or a lookup (kind 1) of the leading
// length bits of prefix, most significant counted bit first; a length above
// ADDRESS_BITS counts as ADDRESS_BITS. An insert creates missing nodes along
// its path, stops at any node that already ends a prefix, and otherwise marks
// the node reached after length bits. A lookup hits when its path meets a
// marked node. Every item gives exactly one result item: hit, the node count
// after the item, and pool_full when an insert needed a node while all NODES
// were taken (nodes created earlier on its path stay). The block takes one
// item at a time: it accepts an item, visits at most length + 1 trie levels
// (so up to ADDRESS_BITS + 1), then holds the result until it is taken, and
// only then accepts the next item. The walk is paced by the single node
// memory: each level of a stored path is one registered read followed by the
// decision that picks the next address. Node memory needs no clearing after
// reset: a node is written in full when allocated.
// ----------------------------------------------------------------------------
module binary_trie_prefix_filter
	import btpf_pkg::*;
#(
	parameter int NODES        = BTPF_NODES,
	parameter int ADDRESS_BITS = BTPF_ADDRESS_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	btpf_req_if.sink   req,
	btpf_rsp_if.source rsp
);

	localparam int IDXW = $clog2(NODES);
	localparam int CNTW = $clog2(NODES + 1);
	localparam int LENW = $clog2(ADDRESS_BITS + 1);
	localparam int BITW = $clog2(ADDRESS_BITS);
	localparam int RECW = 1 + 2 * IDXW;

	// one trie node as stored; a child link of zero means no child
	typedef struct packed {
		logic            mark;
		logic [IDXW-1:0] left;
		logic [IDXW-1:0] right;
	} node_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,   // read data of node_q is on the memory output
		ST_GROW = 4'b0100,   // node_q is freshly allocated, contents known zero
		ST_DONE = 4'b1000
	} state_t;

	state_t                  state_q, state_d;
	logic                    kind_q, kind_d;
	logic [ADDRESS_BITS-1:0] prefix_q, prefix_d;
	logic [LENW-1:0]         len_q, len_d;
	logic [IDXW-1:0]         node_q, node_d;
	logic [CNTW-1:0]         count_q, count_d;
	logic                    hit_q, hit_d;
	logic                    full_q, full_d;

	logic            mem_we;
	logic [IDXW-1:0] mem_waddr;
	node_t           mem_wrec;
	logic            mem_re;
	logic [IDXW-1:0] mem_raddr;
	logic [RECW-1:0] mem_rdata;

	node_t           cur;
	logic [BITW-1:0] bit_idx;
	logic            bit_sel;
	logic [IDXW-1:0] child;
	logic            len_zero;
	logic            pool_out;
	logic [IDXW-1:0] new_idx;
	logic [LENW-1:0] len_in;

	// node memory: mark plus both child links in one word
	btpf_ram #(
		.WIDTH (RECW),
		.DEPTH (NODES)
	) u_nodes (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wrec),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// clamp an oversized length to the address width
	assign len_in = (req.length > LENW'(ADDRESS_BITS)) ? LENW'(ADDRESS_BITS) : req.length;

	assign cur      = node_t'(mem_rdata);
	assign bit_idx  = BITW'(len_q - LENW'(1));
	assign bit_sel  = prefix_q[bit_idx];
	assign child    = bit_sel ? cur.right : cur.left;
	assign len_zero = (len_q == '0);
	assign pool_out = (count_q == CNTW'(NODES));
	assign new_idx  = IDXW'(count_q);

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		prefix_d  = prefix_q;
		len_d     = len_q;
		node_d    = node_q;
		count_d   = count_q;
		hit_d     = hit_q;
		full_d    = full_q;
		mem_we    = 1'b0;
		mem_waddr = node_q;
		mem_wrec  = '0;
		mem_re    = 1'b0;
		mem_raddr = child;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					kind_d   = req.kind;
					prefix_d = req.prefix;
					len_d    = len_in;
					node_d   = '0;
					hit_d    = 1'b0;
					full_d   = 1'b0;
					if (count_q == '0) begin
						if (req.kind == KIND_INSERT) begin
							// empty trie: the root is allocated fresh
							count_d = CNTW'(1);
							state_d = ST_GROW;
						end else begin
							state_d = ST_DONE;
						end
					end else begin
						// start at the root
						mem_re    = 1'b1;
						mem_raddr = '0;
						state_d   = ST_WALK;
					end
				end
			end

			ST_WALK: begin
				if (cur.mark) begin
					hit_d   = (kind_q == KIND_LOOKUP);
					state_d = ST_DONE;
				end else if (len_zero) begin
					if (kind_q == KIND_INSERT) begin
						mem_we        = 1'b1;
						mem_wrec      = cur;
						mem_wrec.mark = 1'b1;
					end
					state_d = ST_DONE;
				end else if (child != '0) begin
					// descend to an existing child
					mem_re  = 1'b1;
					node_d  = child;
					len_d   = len_q - LENW'(1);
				end else if (kind_q == KIND_LOOKUP) begin
					state_d = ST_DONE;
				end else if (pool_out) begin
					full_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					// link a new node into this one and continue on fresh nodes
					mem_we   = 1'b1;
					mem_wrec = cur;
					if (bit_sel) begin
						mem_wrec.right = new_idx;
					end else begin
						mem_wrec.left = new_idx;
					end
					node_d  = new_idx;
					count_d = count_q + CNTW'(1);
					len_d   = len_q - LENW'(1);
					state_d = ST_GROW;
				end
			end

			ST_GROW: begin
				// node_q is written exactly once here, in full
				mem_we = 1'b1;
				if (len_zero) begin
					mem_wrec.mark = 1'b1;
					state_d       = ST_DONE;
				end else if (pool_out) begin
					full_d  = 1'b1;
					state_d = ST_DONE;
				end else begin
					if (bit_sel) begin
						mem_wrec.right = new_idx;
					end else begin
						mem_wrec.left = new_idx;
					end
					node_d  = new_idx;
					count_d = count_q + CNTW'(1);
					len_d   = len_q - LENW'(1);
				end
			end

			ST_DONE: begin
				// hold the result item until it is taken
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		prefix_q <= prefix_d;
		len_q    <= len_d;
		node_q   <= node_d;
		hit_q    <= hit_d;
		full_q   <= full_d;
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = (state_q == ST_DONE);
	assign rsp.hit        = hit_q;
	assign rsp.node_count = count_q;
	assign rsp.pool_full  = full_q;

	// never take a new item while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request accepted while a result is pending");

	// the node count never passes the pool size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(NODES))
		else $error("node count beyond pool size");

	// a full report only comes with an exhausted pool
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.pool_full) |-> (count_q == CNTW'(NODES) && kind_q == KIND_INSERT))
		else $error("pool full reported with free nodes left");

	// only lookups hit
	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.hit) |-> (kind_q == KIND_LOOKUP))
		else $error("hit reported for an insert");

endmodule

FILE: bench/btpf_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpf_match_checker: result checker for the prefix filter
// Keeps its own copy of the trie and predicts every result item from the
// accepted request items. It compares each result item field by field with
// the oldest prediction and reports the mismatch count and the number of
// results still due.
// ----------------------------------------------------------------------------
module btpf_match_checker
	import btpf_pkg::*;
#(
	parameter int NODES        = BTPF_NODES,
	parameter int ADDRESS_BITS = BTPF_ADDRESS_BITS
) (
	input  logic clk,
	input  logic arst_n,
	btpf_req_if  req,
	btpf_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);
	localparam int LENW = $clog2(ADDRESS_BITS + 1);
	localparam int CNTW = $clog2(NODES + 1);
	localparam int IDXW = $clog2(NODES);

	typedef struct packed {
		logic            hit;
		logic [CNTW-1:0] node_count;
		logic            pool_full;
	} match_result_t;

	bit            prefix_end[NODES];
	bit [IDXW-1:0] zero_child[NODES];
	bit [IDXW-1:0] one_child[NODES];
	int            nodes_taken;
	match_result_t predicted_matches[$];
	int            fault_count;

	// hand out the next free node, cleared; -1 once the pool is empty
	function automatic int take_node();
		int fresh;
		if (nodes_taken >= NODES) begin
			return -1;
		end
		fresh = nodes_taken;
		prefix_end[fresh] = 1'b0;
		zero_child[fresh] = '0;
		one_child[fresh]  = '0;
		nodes_taken++;
		return fresh;
	endfunction

	function automatic match_result_t walk_trie(logic kind, logic [ADDRESS_BITS-1:0] key,
			logic [LENW-1:0] len);
		int            depth_left;
		int            node;
		int            child;
		bit            full;
		bit            turn;
		match_result_t res;
		depth_left = (len > ADDRESS_BITS) ? ADDRESS_BITS : int'(len);
		full = 1'b0;
		res  = '0;
		if (kind == KIND_INSERT) begin
			node = 0;
			if (nodes_taken == 0) begin
				node = take_node();
			end
			while (!prefix_end[node]) begin
				if (depth_left == 0) begin
					prefix_end[node] = 1'b1;
					break;
				end
				turn  = key[depth_left-1];
				child = int'(turn ? one_child[node] : zero_child[node]);
				if (child == 0) begin
					child = take_node();
					full  = (child < 0);
					if (full) begin
						break;
					end
					if (turn) begin
						one_child[node] = IDXW'(child);
					end else begin
						zero_child[node] = IDXW'(child);
					end
				end
				node = child;
				depth_left--;
			end
		end else if (nodes_taken != 0) begin
			node  = 0;
			child = 1;
			while (child != 0) begin
				if (prefix_end[node]) begin
					res.hit = 1'b1;
					break;
				end
				if (depth_left == 0) begin
					break;
				end
				child = int'(key[depth_left-1] ? one_child[node] : zero_child[node]);
				node  = child;
				depth_left--;
			end
		end
		res.node_count = nodes_taken[CNTW-1:0];
		res.pool_full  = full;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_result_t want;
		if (!arst_n) begin
			nodes_taken = 0;
			fault_count = 0;
			predicted_matches.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready) begin
				predicted_matches.push_back(walk_trie(req.kind, req.prefix, req.length));
			end
			if (rsp.valid && rsp.ready) begin
				if (predicted_matches.size() == 0) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("%0t: result item with nothing due: hit %0d count %0d full %0d",
							$realtime, rsp.hit, rsp.node_count, rsp.pool_full);
					end
				end else begin
					want = predicted_matches.pop_front();
					if (rsp.hit !== want.hit || rsp.node_count !== want.node_count ||
							rsp.pool_full !== want.pool_full) begin
						fault_count++;
						if (fault_count <= 10) begin
							$write("%0t: mismatch: expected hit %0d count %0d full %0d,",
								$realtime, want.hit, want.node_count, want.pool_full);
							$display(" got hit %0d count %0d full %0d",
								rsp.hit, rsp.node_count, rsp.pool_full);
						end
					end
				end
			end
			mismatches  <= fault_count;
			outstanding <= predicted_matches.size();
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the binary trie prefix filter
// Drives a directed opening, a long random mix of inserts and lookups shaped
// around the prefixes already stored, and a closing root mark, with random
// idling on both channels. The checker beside the block does the predicting.
// ----------------------------------------------------------------------------
module testbench;
	import btpf_pkg::*;

	localparam int LENW         = $clog2(BTPF_ADDRESS_BITS + 1);
	localparam int RANDOM_ITEMS = 2000;
	localparam int HOLD_CYCLES  = 300;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;

	// no idling on either side while set
	bit quiet_spell;
	// ask the result side for one long hold-off
	bit hold_results;

	// prefixes sent as inserts, with their counted length (clamped)
	logic [31:0] stored_keys[$];
	int          stored_lens[$];

	btpf_req_if #(.ADDRESS_BITS(BTPF_ADDRESS_BITS)) req_if ();
	btpf_rsp_if #(.NODES(BTPF_NODES))               rsp_if ();

	binary_trie_prefix_filter #(
		.NODES        (BTPF_NODES),
		.ADDRESS_BITS (BTPF_ADDRESS_BITS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	btpf_match_checker #(
		.NODES        (BTPF_NODES),
		.ADDRESS_BITS (BTPF_ADDRESS_BITS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	function automatic int idle_cycles();
		return quiet_spell ? 0 : $urandom_range(0, 17);
	endfunction

	// Place a prefix of head_len bits at the top of a key of key_len counted
	// bits; the bits below it and above the counted range are random.
	function automatic logic [31:0] extend_key(logic [31:0] head, int head_len, int key_len);
		int          eff;
		int          shift;
		logic [63:0] head_mask;
		logic [63:0] rnd;
		logic [63:0] key;
		eff       = (key_len > 32) ? 32 : key_len;
		shift     = eff - head_len;
		head_mask = (64'd1 << head_len) - 64'd1;
		rnd       = {32'h0, $urandom()};
		key       = (rnd & ~(head_mask << shift)) | (({32'h0, head} & head_mask) << shift);
		return key[31:0];
	endfunction

	// Offer one item after a random gap and hold it until accepted. Valid is
	// left high on return so that a back-to-back item needs no second write.
	task automatic offer_item(input logic kind, input logic [31:0] key, input int len);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid  <= 1'b1;
		req_if.kind   <= kind;
		req_if.prefix <= key;
		req_if.length <= len[LENW-1:0];
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		if (kind == KIND_INSERT && len > 0) begin
			stored_keys.push_back(key);
			stored_lens.push_back((len > 32) ? 32 : len);
		end
	endtask

	// Drop valid and hold off until every result has come back.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Result side: random stall before each item, plus one long hold-off on
	// request so the block backs up and stalls its request channel.
	initial begin : result_side
		int stall;
		bit held;
		held = 1'b0;
		rsp_if.ready = 1'b0;
		forever begin
			if (hold_results && !held) begin
				held = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = idle_cycles();
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int          pick;
		int          roll;
		int          idx;
		int          len;
		int          cut;
		int          hlen;
		logic [31:0] head;

		req_if.valid  = 1'b0;
		req_if.kind   = KIND_INSERT;
		req_if.prefix = '0;
		req_if.length = '0;
		quiet_spell   = 1'b0;
		hold_results  = 1'b0;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// lookups on the empty trie miss
		offer_item(KIND_LOOKUP, 32'h0000_0000, 32);
		offer_item(KIND_LOOKUP, 32'hFFFF_FFFF, 0);
		// full-length path of ones: creates root plus 32 nodes
		offer_item(KIND_INSERT, 32'hFFFF_FFFF, 32);
		offer_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32);
		// bits run out one level short of the mark
		offer_item(KIND_LOOKUP, 32'h7FFF_FFFF, 31);
		// oversized lengths count as the full address width
		offer_item(KIND_LOOKUP, 32'hFFFF_FFFF, 63);
		offer_item(KIND_INSERT, 32'h0000_0000, 63);
		offer_item(KIND_LOOKUP, 32'h0000_0000, 32);
		offer_item(KIND_LOOKUP, 32'h0000_0000, 20);
		// zero-length lookup with an unmarked root misses
		offer_item(KIND_LOOKUP, 32'h0000_0000, 0);
		// insert that meets an existing end mark stops there
		offer_item(KIND_INSERT, 32'h0000_0000, 40);
		offer_item(KIND_INSERT, 32'h0000_0002, 2);
		offer_item(KIND_INSERT, 32'h0002_ABCD, 18);
		offer_item(KIND_LOOKUP, 32'h0002_1234, 18);
		offer_item(KIND_LOOKUP, 32'h0000_0002, 2);
		offer_item(KIND_LOOKUP, 32'h0000_0003, 2);
		offer_item(KIND_LOOKUP, 32'h0000_0001, 1);
		// missing child part way down
		offer_item(KIND_LOOKUP, 32'h5555_5555, 32);
		offer_item(KIND_INSERT, 32'h5555_5555, 32);
		offer_item(KIND_LOOKUP, 32'h5555_5555, 32);
		offer_item(KIND_LOOKUP, 32'h5555_5555, 33);
		offer_item(KIND_LOOKUP, 32'h1555_5555, 31);
		wait_drained();

		// Random mix. Fresh inserts fill the pool early on, after which most
		// new paths report pool_full while lookups still walk the full depth.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300) begin
				hold_results = 1'b1;
			end
			if (n == 600) begin
				quiet_spell = 1'b1;
			end
			if (n == 850) begin
				quiet_spell = 1'b0;
			end
			if (n == 1200) begin
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			idx  = $urandom_range(0, stored_keys.size() - 1);
			head = stored_keys[idx];
			hlen = stored_lens[idx];
			if (pick < 30) begin
				// fresh prefix, mostly long, sometimes oversized or short
				roll = $urandom_range(0, 19);
				if (roll < 17) begin
					len = $urandom_range(16, 32);
				end else if (roll < 19) begin
					len = $urandom_range(33, 63);
				end else begin
					len = $urandom_range(6, 15);
				end
				offer_item(KIND_INSERT, $urandom(), len);
			end else if (pick < 40) begin
				// at least as long as a stored prefix: stops at its end mark
				len = $urandom_range(hlen, 40);
				offer_item(KIND_INSERT, extend_key(head, hlen, len), len);
			end else if (pick < 50) begin
				// no longer than a stored prefix: marks a node on its path
				cut = (hlen > 12) ? $urandom_range(1, hlen - 12) : 0;
				offer_item(KIND_INSERT, extend_key(head >> cut, hlen - cut, hlen - cut),
					hlen - cut);
			end else if (pick < 80) begin
				// covered by a stored prefix
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
					: $urandom_range(hlen, 32);
				offer_item(KIND_LOOKUP, extend_key(head, hlen, len), len);
			end else if (pick < 90) begin
				// ends inside a stored path
				cut = $urandom_range(1, hlen);
				offer_item(KIND_LOOKUP, extend_key(head >> cut, hlen - cut, hlen - cut),
					hlen - cut);
			end else begin
				offer_item(KIND_LOOKUP, $urandom(), $urandom_range(0, 63));
			end
		end

		// Zero-length insert marks the root, so every later lookup hits; keep
		// it for the close.
		offer_item(KIND_INSERT, $urandom(), 0);
		offer_item(KIND_LOOKUP, $urandom(), 0);
		offer_item(KIND_LOOKUP, $urandom(), 32);
		offer_item(KIND_INSERT, $urandom(), 32);
		wait_drained();
		repeat (40) @(posedge clk);

		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Hard limit, several times the slowest correct run.
	initial begin : watchdog
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/btpf_pkg.sv
hw/rtl/btpf_req_if.sv
hw/rtl/btpf_rsp_if.sv
hw/rtl/btpf_ram.sv
hw/rtl/binary_trie_prefix_filter.sv
bench/btpf_match_checker.sv
bench/testbench.sv
